// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; pulled in by `include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with active-low reset disable and a fixed message
`define RCFD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// as above, with a caller supplied message
`define RCFD_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

// ----- rtl/rcfd_pkg.sv -----
// types and constants of the rc receiver frame decoder
// no dependencies; used by the top level, the checker and the testbench
package rcfd_pkg;

  localparam int unsigned STORE_DEPTH = 18;
  localparam int unsigned STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = 6;
  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

  localparam int unsigned CH_W   = 11;
  localparam int unsigned VAL_W  = 12;
  localparam int unsigned NUM_CH = 5;

  localparam logic [CH_W-1:0] CH_RESET       = 11'd1024;
  localparam logic [3:0]      SWITCHES_RESET = 4'd5;
  localparam logic [CH_W-1:0] OFFSET_RESET   = 11'd1024;
  localparam logic [7:0]      DEADBAND_RESET = 8'd10;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND      = 1'd1;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic                    frame_ok;
    logic signed [VAL_W-1:0] ch0_value;
    logic signed [VAL_W-1:0] ch1_value;
    logic signed [VAL_W-1:0] ch2_value;
    logic signed [VAL_W-1:0] ch3_value;
    logic signed [VAL_W-1:0] ch4_value;
    logic [3:0]              switches;
    logic signed [15:0]      mouse_x;
    logic signed [15:0]      mouse_y;
    logic [15:0]             mouse_buttons;
    logic [15:0]             key_mask;
    logic [16:0]             key_rise;
  } out_item_t;

endpackage

// ----- rtl/rcfd_stream_if.sv -----
// valid/ready channel carrying one payload of type T per transfer
// depends on nothing; payload types come from rcfd_pkg
interface rcfd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rc_receiver_frame_decoder.sv -----
// rc receiver frame decoder: stores frame bytes, unpacks on line idle
// latency: result valid the cycle after the idle transfer; data bytes give no result
// throughput: one transfer per cycle, held only while a result waits unread
// reset: count and held values to defaults, registers to their reset values
// frame store is not cleared at reset
module rc_receiver_frame_decoder
  import rcfd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rcfd_stream_if.sink          in_i,
  rcfd_stream_if.sink          cfg_i,
  rcfd_stream_if.source        out_o
);

  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BYTES);

  logic [7:0]      store_q [STORE_DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic [CH_W-1:0] held_ch_q [NUM_CH];
  logic [3:0]      held_sw_q;
  logic [15:0]     held_mx_q, held_my_q, held_btn_q, held_keys_q;
  logic [CH_W-1:0] offset_q;
  logic [7:0]      deadband_q;
  logic            out_valid_q;
  out_item_t       out_data_q, out_data_d;

  logic            in_fire, data_fire, idle_fire, len_ok, frame_good;
  logic [CH_W-1:0] unp_ch [NUM_CH];
  logic [CH_W-1:0] sel_ch [NUM_CH];
  logic [VAL_W-1:0] cen_ch [NUM_CH];
  logic [3:0]      unp_sw, sel_sw;
  logic [15:0]     unp_mx, unp_my, unp_btn, unp_keys;
  logic [15:0]     sel_mx, sel_my, sel_btn, sel_keys;
  logic [16:0]     rise;

  function automatic logic [VAL_W-1:0] centred(input logic [CH_W-1:0] raw,
                                               input logic [CH_W-1:0] off,
                                               input logic [7:0] band);
    logic signed [VAL_W-1:0] diff;
    logic [VAL_W-1:0]        mag;
    diff = $signed({1'b0, raw}) - $signed({1'b0, off});
    mag  = diff[VAL_W-1] ? VAL_W'(-diff) : diff;
    if (mag < {4'b0, band}) begin
      return '0;
    end
    return diff;
  endfunction

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign in_fire    = in_i.valid && in_i.ready;
  assign data_fire  = in_fire && !in_i.data.func;
  assign idle_fire  = in_fire && in_i.data.func;
  assign len_ok     = (count_q == FRAME_CNT);
  assign frame_good = idle_fire && len_ok;

  // little-endian unpack of the stored frame
  always_comb begin
    unp_ch[0] = {store_q[1][2:0], store_q[0]};
    unp_ch[1] = {store_q[2][5:0], store_q[1][7:3]};
    unp_ch[2] = {store_q[4][0], store_q[3], store_q[2][7:6]};
    unp_ch[3] = {store_q[5][3:0], store_q[4][7:1]};
    unp_ch[4] = {store_q[17][2:0], store_q[16]};
    unp_sw    = store_q[5][7:4];
    unp_mx    = {store_q[7], store_q[6]};
    unp_my    = {store_q[9], store_q[8]};
    unp_btn   = {store_q[13], store_q[12]};
    unp_keys  = {store_q[15], store_q[14]};
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sel_ch[i] = len_ok ? unp_ch[i] : held_ch_q[i];
      cen_ch[i] = centred(sel_ch[i], offset_q, deadband_q);
    end
    sel_sw   = len_ok ? unp_sw   : held_sw_q;
    sel_mx   = len_ok ? unp_mx   : held_mx_q;
    sel_my   = len_ok ? unp_my   : held_my_q;
    sel_btn  = len_ok ? unp_btn  : held_btn_q;
    sel_keys = len_ok ? unp_keys : held_keys_q;
    // rising edges only against the last good frame
    rise = '0;
    if (len_ok) begin
      rise[15:0] = ~held_keys_q & unp_keys;
      rise[16]   = (held_btn_q[7:0] == 8'd0) && (unp_btn[7:0] != 8'd0);
    end
  end

  always_comb begin
    out_data_d.frame_ok      = len_ok;
    out_data_d.ch0_value     = cen_ch[0];
    out_data_d.ch1_value     = cen_ch[1];
    out_data_d.ch2_value     = cen_ch[2];
    out_data_d.ch3_value     = cen_ch[3];
    out_data_d.ch4_value     = cen_ch[4];
    out_data_d.switches      = sel_sw;
    out_data_d.mouse_x       = sel_mx;
    out_data_d.mouse_y       = sel_my;
    out_data_d.mouse_buttons = sel_btn;
    out_data_d.key_mask      = sel_keys;
    out_data_d.key_rise      = rise;
  end

  always_comb begin
    count_d = count_q;
    if (idle_fire) begin
      count_d = '0;
    end else if (data_fire && (count_q < COUNT_MAX)) begin
      count_d = count_q + 1'b1;
    end
  end

  // bytes past the store are counted but dropped
  always_ff @(posedge clk_i) begin
    if (data_fire && (count_q < CNT_W'(STORE_DEPTH))) begin
      store_q[count_q[STORE_IDX_W-1:0]] <= in_i.data.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        held_ch_q[i] <= CH_RESET;
      end
      held_sw_q   <= SWITCHES_RESET;
      held_mx_q   <= '0;
      held_my_q   <= '0;
      held_btn_q  <= '0;
      held_keys_q <= '0;
      offset_q    <= OFFSET_RESET;
      deadband_q  <= DEADBAND_RESET;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (frame_good) begin
        for (int i = 0; i < NUM_CH; i++) begin
          held_ch_q[i] <= unp_ch[i];
        end
        held_sw_q   <= unp_sw;
        held_mx_q   <= unp_mx;
        held_my_q   <= unp_my;
        held_btn_q  <= unp_btn;
        held_keys_q <= unp_keys;
      end
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          CFG_CENTER_OFFSET: offset_q   <= cfg_i.data.wdata[CH_W-1:0];
          CFG_DEADBAND:      deadband_q <= cfg_i.data.wdata[7:0];
          default: ;
        endcase
      end
      if (idle_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (idle_fire) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

// ----- rtl/rcfd_checker.sv -----
// port-level checks on the rc receiver frame decoder, bound to the top level
// depends on rcfd_pkg and assert_macros.svh
`include "assert_macros.svh"

module rcfd_checker
  import rcfd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      in_func_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // a new result only follows an idle transfer
  `RCFD_ASSERT_MSG(a_result_from_idle, clk_i, rst_ni, out_valid_i && (!$past(out_valid_i) || $past(out_ready_i)) |-> $past(in_valid_i && in_ready_i && in_func_i), "result without idle transfer")

  `RCFD_ASSERT(a_bad_frame_no_rise, clk_i, rst_ni, out_valid_i && !out_data_i.frame_ok |-> out_data_i.key_rise == 17'd0)

  `RCFD_ASSERT(a_left_rise_pressed, clk_i, rst_ni, out_valid_i && out_data_i.key_rise[16] |-> out_data_i.mouse_buttons[7:0] != 8'd0)

  // stalled result holds
  `RCFD_ASSERT_MSG(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "stalled result changed")

endmodule

bind rc_receiver_frame_decoder rcfd_checker u_rcfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.data.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// ----- verif/tb_rc_receiver_frame_decoder.sv -----
// testbench for rc_receiver_frame_decoder: random byte streams and idle events in,
// decoded frame reports checked field by field against an in-bench decoder
// depends on rcfd_pkg, rcfd_stream_if and the rtl top level
module tb_rc_receiver_frame_decoder;
  import rcfd_pkg::*;

  localparam int unsigned FRAME_LEN   = 18;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          NUM_PHASES  = 7;
  localparam int          PHASE_ITEMS = 145;

  logic clk_i;
  logic rst_ni;

  rcfd_stream_if #(.T(in_item_t))  in_if ();
  rcfd_stream_if #(.T(cfg_item_t)) cfg_if ();
  rcfd_stream_if #(.T(out_item_t)) out_if ();

  rc_receiver_frame_decoder #(
    .FRAME_BYTES(FRAME_LEN)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  // decoder state and register copies
  logic [CH_W-1:0]  cur_offset   = OFFSET_RESET;
  logic [7:0]       cur_deadband = DEADBAND_RESET;
  logic [7:0]       frame_mem [STORE_DEPTH];
  logic [CNT_W-1:0] rx_count = '0;
  logic [CH_W-1:0]  held_ch [NUM_CH];
  logic [3:0]       held_sw   = SWITCHES_RESET;
  logic [15:0]      held_mx   = '0;
  logic [15:0]      held_my   = '0;
  logic [15:0]      held_btn  = '0;
  logic [15:0]      held_keys = '0;

  in_item_t  rx_events_q [$];
  out_item_t frame_reports_q [$];

  int err_count   = 0;
  int cycle_count = 0;
  int long_hold_cycles = 0;
  int items_queued = 0;

  initial begin
    for (int i = 0; i < NUM_CH; i++) held_ch[i] = CH_RESET;
  end

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_error(string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    err_count++;
  endtask

  function automatic logic [VAL_W-1:0] centre_ch(logic [CH_W-1:0] raw);
    int d;
    int mag;
    d = int'(raw) - int'(cur_offset);
    mag = (d < 0) ? -d : d;
    if (mag < int'(cur_deadband)) return '0;
    return d[VAL_W-1:0];
  endfunction

  // data bytes only fill the store, an idle event closes the frame and yields a report
  function automatic void decode_event(in_item_t ev);
    out_item_t   r;
    logic [47:0] w;
    logic [15:0] old_keys;
    logic [7:0]  old_left;
    logic [16:0] rise;
    logic        ok;
    if (ev.func == 1'b0) begin
      if (rx_count < STORE_DEPTH) frame_mem[rx_count] = ev.rx_byte;
      if (rx_count != COUNT_MAX) rx_count++;
      return;
    end
    ok = 1'b0;
    rise = '0;
    if (rx_count == FRAME_LEN) begin
      old_keys = held_keys;
      old_left = held_btn[7:0];
      w = {frame_mem[5], frame_mem[4], frame_mem[3], frame_mem[2], frame_mem[1], frame_mem[0]};
      held_ch[0] = w[10:0];
      held_ch[1] = w[21:11];
      held_ch[2] = w[32:22];
      held_ch[3] = w[43:33];
      held_ch[4] = {frame_mem[17][2:0], frame_mem[16]};
      held_sw   = w[47:44];
      held_mx   = {frame_mem[7], frame_mem[6]};
      held_my   = {frame_mem[9], frame_mem[8]};
      held_btn  = {frame_mem[13], frame_mem[12]};
      held_keys = {frame_mem[15], frame_mem[14]};
      ok = 1'b1;
      rise[15:0] = ~old_keys & held_keys;
      rise[16]   = (old_left == 8'd0) && (held_btn[7:0] != 8'd0);
    end
    rx_count = '0;
    r.frame_ok      = ok;
    r.ch0_value     = centre_ch(held_ch[0]);
    r.ch1_value     = centre_ch(held_ch[1]);
    r.ch2_value     = centre_ch(held_ch[2]);
    r.ch3_value     = centre_ch(held_ch[3]);
    r.ch4_value     = centre_ch(held_ch[4]);
    r.switches      = held_sw;
    r.mouse_x       = held_mx;
    r.mouse_y       = held_my;
    r.mouse_buttons = held_btn;
    r.key_mask      = held_keys;
    r.key_rise      = rise;
    frame_reports_q.push_back(r);
  endfunction

  // input monitor feeds the decoder on every accepted transfer
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) decode_event(in_if.data);
  end

  task automatic check_field(string name, logic [16:0] got, logic [16:0] want);
    if (got !== want) report_error($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // output monitor
  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (frame_reports_q.size() == 0) begin
        report_error("report with none outstanding");
      end else begin
        want = frame_reports_q.pop_front();
        check_field("frame_ok", got.frame_ok, want.frame_ok);
        check_field("ch0_value", got.ch0_value, want.ch0_value);
        check_field("ch1_value", got.ch1_value, want.ch1_value);
        check_field("ch2_value", got.ch2_value, want.ch2_value);
        check_field("ch3_value", got.ch3_value, want.ch3_value);
        check_field("ch4_value", got.ch4_value, want.ch4_value);
        check_field("switches", got.switches, want.switches);
        check_field("mouse_x", got.mouse_x, want.mouse_x);
        check_field("mouse_y", got.mouse_y, want.mouse_y);
        check_field("mouse_buttons", got.mouse_buttons, want.mouse_buttons);
        check_field("key_mask", got.key_mask, want.key_mask);
        check_field("key_rise", got.key_rise, want.key_rise);
      end
    end
  end

  // driver: bursts of random length with random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!(in_if.valid && !in_if.ready)) begin
      if (rx_events_q.size() != 0 && gap_left == 0) begin
        in_if.valid <= 1'b1;
        in_if.data  <= rx_events_q.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_if.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver: windows of always-ready, a rotating mask, or coin flips, and a forced long hold-off on request
  int         rdy_tick = 0;
  int         rdy_mode = 0;
  logic [7:0] rdy_mask = 8'hff;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (long_hold_cycles > 0) begin
      long_hold_cycles--;
      out_if.ready <= 1'b0;
    end else begin
      rdy_tick++;
      if (rdy_tick % 96 == 0) begin
        rdy_mode = $urandom_range(0, 2);
        rdy_mask = 8'($urandom_range(1, 255));
      end
      rdy_mask = {rdy_mask[6:0], rdy_mask[7]};
      case (rdy_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= rdy_mask[0];
        default: out_if.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  function automatic void push_byte(logic [7:0] b);
    in_item_t ev;
    ev.func    = 1'b0;
    ev.rx_byte = b;
    rx_events_q.push_back(ev);
    items_queued++;
  endfunction

  function automatic void push_idle();
    in_item_t ev;
    ev.func    = 1'b1;
    ev.rx_byte = 8'($urandom_range(0, 255));
    rx_events_q.push_back(ev);
    items_queued++;
  endfunction

  function automatic logic [CH_W-1:0] near_centre();
    int span;
    int v;
    span = int'(cur_deadband) + 2;
    v = int'(cur_offset) + int'($urandom_range(0, 2 * span)) - span;
    return v[CH_W-1:0];
  endfunction

  // well-formed frame with content steered towards deadband edges and button changes
  function automatic void push_good_frame();
    logic [7:0]  b [FRAME_LEN];
    logic [47:0] w;
    logic [15:0] c4;
    int          fill;
    fill = $urandom_range(0, 19);
    for (int i = 0; i < FRAME_LEN; i++) b[i] = 8'($urandom_range(0, 255));
    w = {b[5], b[4], b[3], b[2], b[1], b[0]};
    for (int k = 0; k < 4; k++)
      if ($urandom_range(0, 2) == 0) w[k*11 +: 11] = near_centre();
    for (int i = 0; i < 6; i++) b[i] = w[i*8 +: 8];
    c4 = {b[17], b[16]};
    if ($urandom_range(0, 2) == 0) c4[10:0] = near_centre();
    b[16] = c4[7:0];
    b[17] = c4[15:8];
    if ($urandom_range(0, 2) == 0) b[12] = 8'd0;
    if ($urandom_range(0, 3) == 0) b[14] = 8'd0;
    if ($urandom_range(0, 3) == 0) b[15] = 8'd0;
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (fill == 0) b[i] = 8'h00;
      else if (fill == 1) b[i] = 8'hff;
    end
    for (int i = 0; i < FRAME_LEN; i++) push_byte(b[i]);
    push_idle();
  endfunction

  function automatic void push_bad_frame(int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
    push_idle();
  endfunction

  // wait for the driver to empty and every report to arrive
  task automatic drain();
    do @(posedge clk_i);
    while (rx_events_q.size() != 0 || in_if.valid || frame_reports_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cfg_item_t'{index: idx, wdata: val};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_CENTER_OFFSET) cur_offset = val;
    else cur_deadband = val[7:0];
  endtask

  task automatic set_regs(logic [CH_W-1:0] offs, logic [7:0] db);
    logic [CFG_DATA_W-1:0] db_word;
    db_word = {3'($urandom_range(0, 7)), db};
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_CENTER_OFFSET, offs);
      write_reg(CFG_DEADBAND, db_word);
    end else begin
      write_reg(CFG_DEADBAND, db_word);
      write_reg(CFG_CENTER_OFFSET, offs);
    end
  endtask

  initial begin
    logic [CH_W-1:0] offs_set [NUM_PHASES];
    logic [7:0]      db_set   [NUM_PHASES];
    int              start;
    int              pick;
    offs_set = '{11'd0, 11'd2047, 11'd1024, 11'($urandom), 11'($urandom), 11'd1024,
                 11'($urandom)};
    db_set   = '{8'd0, 8'd255, 8'd10, 8'($urandom), 8'd255, 8'd0, 8'($urandom)};
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle with nothing received, an all-ones frame, a short frame
    push_idle();
    for (int i = 0; i < FRAME_LEN; i++) push_byte(8'hff);
    push_idle();
    push_bad_frame(2);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_regs(offs_set[ph], db_set[ph]);
      // one long receiver hold-off while the sender keeps offering
      if (ph == 2) long_hold_cycles = 400;
      start = items_queued;
      while (items_queued - start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) push_good_frame();
        else if (pick == 7) push_bad_frame($urandom_range(0, FRAME_LEN - 1));
        else if (pick == 8) push_bad_frame($urandom_range(FRAME_LEN + 1, 70));
        else push_idle();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
